// ----- rtl/brf_pkg.sv -----
`default_nettype none
package brf_pkg;

	localparam int unsigned DEPTH_DEF   = 1024;
	localparam int unsigned MAX_RUN_DEF = 64;
	localparam int unsigned CAP_W       = 11;
	localparam int unsigned CAP_RESET   = 1024;
	localparam int unsigned CNT_IN_W    = 7;
	localparam int unsigned BYTE_W      = 8;

	typedef enum logic [1:0] {
		ACT_PUT   = 2'd0,
		ACT_GET   = 2'd1,
		ACT_RUN   = 2'd2,
		ACT_CLEAR = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_EMPTY = 2'd1,
		STAT_FULL  = 2'd2
	} status_t;

	typedef struct packed {
		logic    push;
		logic    put;
		logic    take;
		logic    clear;
		logic    run_load;
		logic    in_run;
		status_t status;
	} cmd_t;

	typedef struct packed {
		logic room;
		logic empty;
		logic full;
		logic run_zero;
		logic run_last;
	} sts_t;

	typedef struct packed {
		logic [CAP_W-1:0]  writable;
		logic [CAP_W-1:0]  readable;
		status_t           status;
		logic              last;
		logic              byte_valid;
		logic [BYTE_W-1:0] out_byte;
	} res_t;

	function automatic logic [CAP_W-1:0] cap_clamp(input logic [CAP_W-1:0] v,
		input int unsigned depth);
		logic [CAP_W-1:0] r;
		r = v;
		if (v == '0) begin
			r = CAP_W'(1);
		end else if (int'(v) > int'(depth)) begin
			r = CAP_W'(depth);
		end
		return r;
	endfunction

endpackage
`default_nettype wire

// ----- rtl/brf_ram.sv -----
`default_nettype none
module brf_ram #(
	parameter int unsigned W = 8,
	parameter int unsigned D = 1024
) (
	input  wire logic                 clk,
	input  wire logic                 we,
	input  wire logic [$clog2(D)-1:0] waddr,
	input  wire logic [W-1:0]         wdata,
	input  wire logic                 re,
	input  wire logic [$clog2(D)-1:0] raddr,
	output logic      [W-1:0]         rdata
);

	logic [W-1:0] mem_q [D];
	logic [W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

// ----- rtl/brf_ctrl.sv -----
`default_nettype none
module brf_ctrl import brf_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    s_valid,
	input  wire action_t action,
	input  wire sts_t    sts,
	output logic         s_ready,
	output cmd_t         cmd
);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_RUN  = 2'b10
	} state_t;

	state_t state_q, state_d;
	logic   accept;

	assign s_ready = (state_q == ST_IDLE) && sts.room;
	assign accept  = s_valid && s_ready;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					unique case (action)
						ACT_PUT: begin
							cmd.push = 1'b1;
							if (sts.full) begin
								cmd.status = STAT_FULL;
							end else begin
								cmd.put = 1'b1;
							end
						end
						ACT_GET: begin
							cmd.push = 1'b1;
							if (sts.empty) begin
								cmd.status = STAT_EMPTY;
							end else begin
								cmd.take = 1'b1;
							end
						end
						ACT_RUN: begin
							if (sts.empty) begin
								cmd.push   = 1'b1;
								cmd.status = STAT_EMPTY;
							end else if (sts.run_zero) begin
								cmd.push = 1'b1;
							end else begin
								cmd.run_load = 1'b1;
								state_d      = ST_RUN;
							end
						end
						ACT_CLEAR: begin
							cmd.push  = 1'b1;
							cmd.clear = 1'b1;
						end
						default: ;
					endcase
				end
			end
			ST_RUN: begin
				if (sts.room) begin
					cmd.push   = 1'b1;
					cmd.take   = 1'b1;
					cmd.in_run = 1'b1;
					if (sts.run_last) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule
`default_nettype wire

// ----- rtl/brf_dpath.sv -----
`default_nettype none
module brf_dpath import brf_pkg::*; #(
	parameter int unsigned DEPTH   = DEPTH_DEF,
	parameter int unsigned MAX_RUN = MAX_RUN_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_wen,
	input  wire logic [CAP_W-1:0]    cfg_wdata,
	input  wire cmd_t                cmd,
	input  wire logic [BYTE_W-1:0]   data_byte,
	input  wire logic [CNT_IN_W-1:0] count,
	output sts_t                     sts,
	output logic                     m_valid,
	input  wire logic                m_ready,
	output res_t                     m_res
);

	localparam int unsigned AW    = $clog2(DEPTH);
	localparam int unsigned PW    = (AW + 1 > CAP_W) ? AW + 1 : CAP_W;
	localparam int unsigned RUN_W = $clog2(MAX_RUN + 1);
	localparam int unsigned QN    = 3;

	logic [CAP_W-1:0]  cap_q;
	logic [AW-1:0]     rp_q, wp_q, rp_nxt, wp_nxt;
	logic [CAP_W-1:0]  held_q, held_nxt;
	logic [CAP_W-1:0]  run_rd_q;
	logic [RUN_W-1:0]  rem_q;
	logic [RUN_W-1:0]  sat_cnt, run_n;
	logic [PW-1:0]     rp_inc, wp_inc;
	logic [BYTE_W-1:0] ram_rdata;

	logic              s1_valid_s1;
	res_t              s1_res_s1;
	res_t              new_res;
	logic [CAP_W-1:0]  new_rd;

	res_t              q_q [QN];
	res_t              q_wdata;
	logic [1:0]        q_wp_q, q_rp_q;
	logic [1:0]        occ_q;
	logic              pop;
	logic [2:0]        fill;

	// position advance with wrap at capacity
	assign rp_inc = PW'(rp_q) + PW'(1);
	assign wp_inc = PW'(wp_q) + PW'(1);
	assign rp_nxt = (rp_inc >= PW'(cap_q)) ? '0 : rp_inc[AW-1:0];
	assign wp_nxt = (wp_inc >= PW'(cap_q)) ? '0 : wp_inc[AW-1:0];

	// run length: min(saturated count, held)
	assign sat_cnt = (int'(count) > int'(MAX_RUN)) ? RUN_W'(MAX_RUN) : count[RUN_W-1:0];
	assign run_n   = (CAP_W'(sat_cnt) < held_q) ? sat_cnt : held_q[RUN_W-1:0];

	assign fill           = 3'(occ_q) + 3'(s1_valid_s1);
	assign sts.room       = fill <= 3'(QN - 1);
	assign sts.empty      = held_q == '0;
	assign sts.full       = held_q == cap_q;
	assign sts.run_zero   = run_n == '0;
	assign sts.run_last   = rem_q == RUN_W'(1);

	always_comb begin
		held_nxt = held_q;
		if (cmd.clear) begin
			held_nxt = '0;
		end else if (cmd.put) begin
			held_nxt = held_q + CAP_W'(1);
		end else if (cmd.take) begin
			held_nxt = held_q - CAP_W'(1);
		end
	end

	assign new_rd              = cmd.in_run ? run_rd_q : held_nxt;
	assign new_res.readable    = new_rd;
	assign new_res.writable    = cap_q - new_rd;
	assign new_res.status      = cmd.status;
	assign new_res.last        = cmd.in_run ? sts.run_last : 1'b1;
	assign new_res.byte_valid  = cmd.take;
	assign new_res.out_byte    = '0;

	brf_ram #(
		.W (BYTE_W),
		.D (DEPTH)
	) u_store (
		.clk   (clk),
		.we    (cmd.put),
		.waddr (wp_q),
		.wdata (data_byte),
		.re    (cmd.take),
		.raddr (rp_q),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q  <= cap_clamp(CAP_W'(CAP_RESET), DEPTH);
			rp_q   <= '0;
			wp_q   <= '0;
			held_q <= '0;
			rem_q  <= '0;
		end else if (cfg_wen) begin
			cap_q  <= cap_clamp(cfg_wdata, DEPTH);
			rp_q   <= '0;
			wp_q   <= '0;
			held_q <= '0;
		end else begin
			held_q <= held_nxt;
			if (cmd.clear) begin
				rp_q <= '0;
				wp_q <= '0;
			end else begin
				if (cmd.put) begin
					wp_q <= wp_nxt;
				end
				if (cmd.take) begin
					rp_q <= rp_nxt;
				end
			end
			if (cmd.run_load) begin
				rem_q <= run_n;
			end else if (cmd.in_run) begin
				rem_q <= rem_q - RUN_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.run_load) begin
			run_rd_q <= held_q - CAP_W'(run_n);
		end
		if (cmd.push) begin
			s1_res_s1 <= new_res;
		end
	end

	// result queue
	assign pop     = m_valid && m_ready;
	assign m_valid = occ_q != '0;
	assign m_res   = q_q[q_rp_q];

	always_comb begin
		q_wdata          = s1_res_s1;
		q_wdata.out_byte = s1_res_s1.byte_valid ? ram_rdata : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_s1 <= 1'b0;
			q_wp_q      <= '0;
			q_rp_q      <= '0;
			occ_q       <= '0;
		end else begin
			s1_valid_s1 <= cmd.push;
			if (s1_valid_s1) begin
				q_wp_q <= (q_wp_q == 2'(QN - 1)) ? '0 : q_wp_q + 2'd1;
			end
			if (pop) begin
				q_rp_q <= (q_rp_q == 2'(QN - 1)) ? '0 : q_rp_q + 2'd1;
			end
			occ_q <= occ_q + 2'(s1_valid_s1) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (s1_valid_s1) begin
			q_q[q_wp_q] <= q_wdata;
		end
	end

`ifndef SYNTH
	a_queue_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid_s1 |-> (occ_q != 2'(QN) || pop))
		else $error("result queue overflow");
	a_held_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		held_q <= cap_q)
		else $error("held count above capacity");
	a_no_put_full: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.put |-> held_q != cap_q)
		else $error("store written while full");
	a_no_take_empty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.take |-> held_q != '0)
		else $error("byte taken while empty");
`endif

endmodule
`default_nettype wire

// ----- rtl/byte_ring_fifo_unit.sv -----
// ordering: a put, get or clear result is registered in the s1 stage, then written
// into the three-entry result queue before it leaves the output; a read run first
// takes a setup step that loads its length, then its bytes take the same path
// throughput: put, get and clear are accepted back to back and a read run gives one
// byte per cycle through the single read port of the store, while the queue has room
// reset: positions, held count and queue clear at once, capacity goes to 1024
// (limited to DEPTH); store contents are not cleared
`default_nettype none
module byte_ring_fifo_unit import brf_pkg::*; #(
	parameter int unsigned DEPTH   = DEPTH_DEF,
	parameter int unsigned MAX_RUN = MAX_RUN_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             s_tvalid,
	output logic                  s_tready,
	input  wire logic [15:0]      s_tdata,   // data_byte, count
	input  wire logic [1:0]       s_tuser,   // action
	output logic                  m_tvalid,
	input  wire logic             m_tready,
	output logic      [31:0]      m_tdata,   // out_byte, readable, writable
	output logic      [2:0]       m_tuser,   // byte_valid, status
	output logic                  m_tlast,
	input  wire logic             cfg_wen,
	input  wire logic [CAP_W-1:0] cfg_wdata
);

	cmd_t    cmd;
	sts_t    sts;
	res_t    res;
	action_t action;

	assign action = action_t'(s_tuser);

	brf_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_valid (s_tvalid),
		.action  (action),
		.sts     (sts),
		.s_ready (s_tready),
		.cmd     (cmd)
	);

	brf_dpath #(
		.DEPTH   (DEPTH),
		.MAX_RUN (MAX_RUN)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_wdata (cfg_wdata),
		.cmd       (cmd),
		.data_byte (s_tdata[7:0]),
		.count     (s_tdata[14:8]),
		.sts       (sts),
		.m_valid   (m_tvalid),
		.m_ready   (m_tready),
		.m_res     (res)
	);

	assign m_tdata = {2'b00, res.writable, res.readable, res.out_byte};
	assign m_tuser = {res.status, res.byte_valid};
	assign m_tlast = res.last;

endmodule
`default_nettype wire
